[sv/gmag_pkg.sv]
// gmag_pkg: shared types and constants of the 3x3 gradient magnitude unit
// no dependencies; used by the top level, the line store ram user and the checker
`default_nettype none

package gmag_pkg;

  localparam int PIX_W = 8;
  localparam int CFG_W = 12;
  localparam int MODE_W = 2;
  localparam int IDX_W = 2;
  localparam int SUM_W = 12;

  // configuration register indexes
  localparam logic [IDX_W-1:0] CFG_IMAGE_WIDTH = 2'd0;
  localparam logic [IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] CFG_KERNEL_MODE = 2'd2;

  // kernel pair codes
  localparam logic [MODE_W-1:0] MODE_SOBEL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PREWITT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ROBERTS = 2'd2;

  localparam logic [CFG_W-1:0] WIDTH_RESET = 12'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;
  localparam logic [MODE_W-1:0] MODE_RESET = MODE_SOBEL;

  // per-item flags carried from the counter stage to the window stage
  typedef struct packed {
    logic col_zero;
    logic top_ok;
    logic mid_ok;
    logic wr_ok;
    logic emit;
    logic last;
  } win_info_t;

  // partial state of the digit-by-digit square root
  typedef struct packed {
    logic [9:0] rem;
    logic [7:0] root;
  } sq_part_t;

endpackage

`default_nettype wire

[sv/gmag_ram.sv]
// gmag_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module gmag_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[sv/gradient_magnitude_3x3_unit.sv]
// gradient_magnitude_3x3_unit: streaming 3x3 gradient magnitude with line stores
// depends on gmag_pkg and gmag_ram
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid in_ready in_pixel                | sink
//  out     | out_valid out_ready out_magnitude         | source
//          | out_grad_first out_grad_second            |
//          | out_frame_last                            |
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data    | sink
//
// one item per cycle while out_ready is high and no clearing pass runs.
// the line store ram (one read, one write per cycle) sets the one-cycle item rate.
// after reset a clearing pass zeroes the MAX_WIDTH line store words; in_ready
// stays low meanwhile, cfg writes are taken at any time.
// each pipeline stage holds under a stall and fills its own bubble independently.
`default_nettype none

module gradient_magnitude_3x3_unit #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [gmag_pkg::PIX_W-1:0]  in_pixel,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [gmag_pkg::PIX_W-1:0]  out_magnitude,
  output logic      [gmag_pkg::PIX_W-1:0]  out_grad_first,
  output logic      [gmag_pkg::PIX_W-1:0]  out_grad_second,
  output logic                             out_frame_last,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [gmag_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [gmag_pkg::CFG_W-1:0]  cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int PW = gmag_pkg::PIX_W;
  localparam int CW = gmag_pkg::CFG_W;
  localparam int SW = gmag_pkg::SUM_W;

  // configuration
  logic [CW-1:0] width_r, height_r;
  logic [gmag_pkg::MODE_W-1:0] mode_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= gmag_pkg::WIDTH_RESET;
      height_r <= gmag_pkg::HEIGHT_RESET;
      mode_r <= gmag_pkg::MODE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gmag_pkg::CFG_IMAGE_WIDTH: width_r <= cfg_data;
        gmag_pkg::CFG_IMAGE_HEIGHT: height_r <= cfg_data;
        gmag_pkg::CFG_KERNEL_MODE: mode_r <= cfg_data[gmag_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CW-1:0] w_eff, h_eff;

  always_comb begin
    if (width_r == '0) begin
      w_eff = CW'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    h_eff = (height_r == '0) ? CW'(1) : height_r;
  end

  // clearing pass over the line store after reset
  logic [AW:0] clr_cnt_r, clr_cnt_nxt;
  logic clr_busy_r, clr_busy_nxt;

  always_comb begin
    clr_cnt_nxt = clr_cnt_r;
    clr_busy_nxt = clr_busy_r;
    if (clr_busy_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (32'(clr_cnt_r) == MAX_WIDTH - 1) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      clr_busy_r <= 1'b1;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
      clr_busy_r <= clr_busy_nxt;
    end
  end

  // stage handshake chain
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic en1, en2, en3, en4, en5, acc, done1;

  assign en5 = !out_valid_r || out_ready;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ready = en1 && !clr_busy_r;
  assign acc = in_valid && in_ready;
  assign done1 = v1_r && en2;

  // stage 0: position counters, line store read
  logic [CW-1:0] col_r, col_nxt, row_r, row_nxt;
  logic c_lt_w, in_frame;
  gmag_pkg::win_info_t info0;
  logic [AW+CW-1:0] col_ext;
  logic [AW-1:0] rd_addr;

  assign c_lt_w = col_r < w_eff;
  assign in_frame = c_lt_w && (row_r < h_eff);
  assign col_ext = {{AW{1'b0}}, col_r};
  assign rd_addr = col_ext[AW-1:0];

  always_comb begin
    info0.col_zero = (col_r == '0);
    info0.top_ok = c_lt_w && (row_r >= CW'(2));
    info0.mid_ok = c_lt_w && (row_r >= CW'(1));
    info0.wr_ok = c_lt_w;
    info0.emit = (row_r >= CW'(1)) && (col_r >= CW'(1)) && (row_r <= h_eff)
                 && (col_r <= w_eff);
    info0.last = (row_r == h_eff) && (col_r == w_eff);
    col_nxt = col_r;
    row_nxt = row_r;
    if (!c_lt_w) begin
      col_nxt = '0;
      row_nxt = (row_r >= h_eff) ? '0 : row_r + 1'b1;
    end else begin
      col_nxt = col_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // stage 1 registers
  gmag_pkg::win_info_t info1_r;
  logic [PW-1:0] p1_r;
  logic [AW-1:0] a1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      info1_r <= info0;
      p1_r <= in_frame ? in_pixel : '0;
      a1_r <= rd_addr;
    end
  end

  // line store: upper row in the high byte, middle row in the low byte
  logic ram_we;
  logic [AW-1:0] ram_waddr;
  logic [2*PW-1:0] ram_wdata, ram_rdata;
  logic [PW-1:0] top, mid;

  assign top = info1_r.top_ok ? ram_rdata[2*PW-1:PW] : '0;
  assign mid = info1_r.mid_ok ? ram_rdata[PW-1:0] : '0;

  always_comb begin
    if (clr_busy_r) begin
      ram_we = 1'b1;
      ram_waddr = clr_cnt_r[AW-1:0];
      ram_wdata = '0;
    end else begin
      ram_we = done1 && info1_r.wr_ok;
      ram_waddr = a1_r;
      ram_wdata = {mid, p1_r};
    end
  end

  gmag_ram #(
    .WIDTH(2 * PW),
    .DEPTH(MAX_WIDTH)
  ) u_line_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (acc),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  // window: left and middle columns, index 0 top row to 2 bottom row
  logic [PW-1:0] wl_r [3];
  logic [PW-1:0] wm_r [3];
  logic [PW-1:0] wl [3];
  logic [PW-1:0] wm [3];
  logic [PW-1:0] wr [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wl[i] = info1_r.col_zero ? '0 : wl_r[i];
      wm[i] = info1_r.col_zero ? '0 : wm_r[i];
    end
    wr[0] = top;
    wr[1] = mid;
    wr[2] = p1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        wl_r[i] <= '0;
        wm_r[i] <= '0;
      end
    end else if (done1) begin
      for (int i = 0; i < 3; i++) begin
        wl_r[i] <= wm[i];
        wm_r[i] <= wr[i];
      end
    end
  end

  // kernel responses
  logic signed [SW-1:0] x0, x1, x2, x3, x4, x5, x6, x7, x8;
  logic signed [SW-1:0] s_first, s_second;

  assign x0 = $signed({{(SW-PW){1'b0}}, wl[0]});
  assign x1 = $signed({{(SW-PW){1'b0}}, wm[0]});
  assign x2 = $signed({{(SW-PW){1'b0}}, wr[0]});
  assign x3 = $signed({{(SW-PW){1'b0}}, wl[1]});
  assign x4 = $signed({{(SW-PW){1'b0}}, wm[1]});
  assign x5 = $signed({{(SW-PW){1'b0}}, wr[1]});
  assign x6 = $signed({{(SW-PW){1'b0}}, wl[2]});
  assign x7 = $signed({{(SW-PW){1'b0}}, wm[2]});
  assign x8 = $signed({{(SW-PW){1'b0}}, wr[2]});

  always_comb begin
    case (mode_r)
      gmag_pkg::MODE_SOBEL: begin
        s_first = x6 + (x7 <<< 1) + x8 - x0 - (x1 <<< 1) - x2;
        s_second = x2 + (x5 <<< 1) + x8 - x0 - (x3 <<< 1) - x6;
      end
      gmag_pkg::MODE_PREWITT: begin
        s_first = x6 + x7 + x8 - x0 - x1 - x2;
        s_second = x2 + x5 + x8 - x0 - x3 - x6;
      end
      default: begin
        // roberts cross, also for the unused code
        s_first = x4 - x8;
        s_second = x5 - x7;
      end
    endcase
  end

  function automatic logic [PW-1:0] clamp_pix(input logic signed [SW-1:0] v);
    logic [PW-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > $signed(SW'((1 << PW) - 1))) begin
      res = '1;
    end else begin
      res = v[PW-1:0];
    end
    return res;
  endfunction

  // stage 2: clamped responses
  logic [PW-1:0] a2_r, b2_r;
  logic last2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= done1 && info1_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      a2_r <= clamp_pix(s_first);
      b2_r <= clamp_pix(s_second);
      last2_r <= info1_r.last;
    end
  end

  // stage 3: sum of squares
  logic [2*PW:0] sq3_r;
  logic [PW-1:0] a3_r, b3_r;
  logic last3_r;
  logic [2*PW-1:0] sq_a, sq_b;

  assign sq_a = a2_r * a2_r;
  assign sq_b = b2_r * b2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      sq3_r <= {1'b0, sq_a} + {1'b0, sq_b};
      a3_r <= a2_r;
      b3_r <= b2_r;
      last3_r <= last2_r;
    end
  end

  // square root, four result bits per stage
  function automatic gmag_pkg::sq_part_t sqrt_step4(input gmag_pkg::sq_part_t st,
                                                     input logic [7:0] bits);
    gmag_pkg::sq_part_t s;
    logic [9:0] trial;
    s = st;
    for (int i = 3; i >= 0; i--) begin
      s.rem = {s.rem[7:0], bits[2*i +: 2]};
      trial = {s.root, 2'b01};
      if (s.rem >= trial) begin
        s.rem = s.rem - trial;
        s.root = {s.root[6:0], 1'b1};
      end else begin
        s.root = {s.root[6:0], 1'b0};
      end
    end
    return s;
  endfunction

  gmag_pkg::sq_part_t part3, part4, part4_r;
  logic [7:0] lo4_r;
  logic sat4_r, last4_r;
  logic [PW-1:0] a4_r, b4_r;

  assign part3 = sqrt_step4('0, sq3_r[15:8]);
  assign part4 = sqrt_step4(part4_r, lo4_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      part4_r <= part3;
      lo4_r <= sq3_r[7:0];
      // a sum of 2^16 or more has a root of at least 256
      sat4_r <= sq3_r[2*PW];
      a4_r <= a3_r;
      b4_r <= b3_r;
      last4_r <= last3_r;
    end
  end

  // output register
  logic [PW-1:0] mag_r, first_r, second_r;
  logic last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en5) begin
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      mag_r <= sat4_r ? '1 : part4.root;
      first_r <= a4_r;
      second_r <= b4_r;
      last_r <= last4_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_magnitude = mag_r;
  assign out_grad_first = first_r;
  assign out_grad_second = second_r;
  assign out_frame_last = last_r;

endmodule

`default_nettype wire

[sv/gmag_checker.sv]
// gmag_checker: port-level assertions for gradient_magnitude_3x3_unit
// depends on gmag_pkg; bound to the top level below
`default_nettype none

module gmag_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [gmag_pkg::PIX_W-1:0] out_magnitude,
  input wire logic [gmag_pkg::PIX_W-1:0] out_grad_first,
  input wire logic [gmag_pkg::PIX_W-1:0] out_grad_second,
  input wire logic                       out_frame_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_magnitude)
      && $stable(out_grad_first) && $stable(out_grad_second) && $stable(out_frame_last))
    else $error("stalled result changed");

  // line store clearing keeps the input closed right after reset
  a_clear_blocks: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("item taken during clearing pass");

  // root of a sum of squares is at least the larger response
  a_mag_lower: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_magnitude >= out_grad_first) && (out_magnitude >= out_grad_second))
    else $error("magnitude below a response");

  // and at most the sum of both responses
  a_mag_upper: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> {1'b0, out_magnitude} <= ({1'b0, out_grad_first} + {1'b0, out_grad_second}))
    else $error("magnitude above the response sum");

endmodule

bind gradient_magnitude_3x3_unit gmag_checker u_gmag_checker (.*);

`default_nettype wire
